### design/ledring_pkg.sv
// Package for the LED ring pattern generator.
// Holds widths, mode and register codes, reset values, shared types and the
// color wheel and level scaling functions. Depends on nothing.
package ledring_pkg;

	localparam int RING_LEDS_DEF = 16;
	localparam int MODE_W        = 2;
	localparam int SHOWN_W       = 3;
	localparam int CH_W          = 8;
	localparam int PIX_IDX_W     = 6;
	localparam int CFG_IDX_W     = 4;
	localparam int PROD_W        = 2 * CH_W;

	localparam logic [MODE_W-1:0] MODE_TITLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OVER  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_WIN   = 2'd3;

	localparam logic [SHOWN_W-1:0] SHOWN_NONE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TITLE_LEVEL = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLAY_STEP   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_STEP    = 4'd3;

	localparam logic [CH_W-1:0] BRIGHTNESS_RST  = 8'd32;
	localparam logic [CH_W-1:0] TITLE_LEVEL_RST = 8'd16;
	localparam logic [CH_W-1:0] PLAY_STEP_RST   = 8'd4;
	localparam logic [CH_W-1:0] WIN_STEP_RST    = 8'd32;

	localparam logic [CH_W-1:0] WHEEL_SEG1 = 8'd85;
	localparam logic [CH_W-1:0] WHEEL_SEG2 = 8'd170;
	localparam logic [CH_W-1:0] CH_MAX     = 8'd255;

	typedef struct packed {
		logic [CH_W-1:0] brightness;
		logic [CH_W-1:0] title_level;
		logic [CH_W-1:0] play_hue_step;
		logic [CH_W-1:0] victory_hue_step;
	} cfg_regs_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic            rainbow;
		logic [CH_W-1:0] hue;
		rgb_t            color;
	} frame_desc_t;

	// Three-segment wheel: red to green, green to blue, blue to red.
	function automatic rgb_t wheel_color(input logic [CH_W-1:0] pos);
		logic [CH_W-1:0] q;
		logic [CH_W-1:0] up;
		logic [CH_W-1:0] down;
		rgb_t            c;
		if (pos < WHEEL_SEG1) begin
			q = pos;
		end else if (pos < WHEEL_SEG2) begin
			q = pos - WHEEL_SEG1;
		end else begin
			q = pos - WHEEL_SEG2;
		end
		up   = CH_W'({2'b00, q} + {1'b0, q, 1'b0});
		down = CH_MAX - up;
		if (pos < WHEEL_SEG1) begin
			c = '{red: down, green: up, blue: '0};
		end else if (pos < WHEEL_SEG2) begin
			c = '{red: '0, green: down, blue: up};
		end else begin
			c = '{red: up, green: '0, blue: down};
		end
		return c;
	endfunction

	// Exact floor(x / 255) for any product of two 8-bit levels.
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] sum;
		sum = {1'b0, x} + (PROD_W+1)'(1) + (PROD_W+1)'(x[PROD_W-1:CH_W]);
		return sum[PROD_W-1:CH_W];
	endfunction

endpackage

### design/ledring_ifs.sv
// Handshake channel interfaces of the LED ring pattern generator:
// frame ticks in, pixels out, and register writes.
// Depends on ledring_pkg.
interface frame_tick_if import ledring_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] game_mode;

	modport source (output valid, output game_mode, input ready);
	modport sink (input valid, input game_mode, output ready);
endinterface

interface pixel_if import ledring_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PIX_IDX_W-1:0] pixel_index;
	logic [CH_W-1:0]      red;
	logic [CH_W-1:0]      green;
	logic [CH_W-1:0]      blue;
	logic                 last_pixel;

	modport source (output valid, output pixel_index, output red, output green,
		output blue, output last_pixel, input ready);
	modport sink (input valid, input pixel_index, input red, input green,
		input blue, input last_pixel, output ready);
endinterface

interface cfg_wr_if import ledring_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CH_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/led_ring_pattern_generator_top.sv
// Top level of the LED ring pattern generator.
// Instantiates the register file, frame control and pixel generator.
// Depends on ledring_pkg, ledring_ifs and the ledring_* modules.
//
// Each frame tick on the tick channel yields either nothing or one frame of
// RING_LEDS pixels on the pixel channel, one pixel per cycle while the sink
// is ready, with last_pixel set on the final one. The pixel sequencer sets
// the rate: it takes one frame at a time, and one further tick is held as
// a pending frame, so the next frame follows the previous one without a
// gap. The first pixel of a tick passes the description, sequencer, product
// and output registers. Register writes are taken in any cycle and should
// be made while no frame is pending or streaming.
module led_ring_pattern_generator_top import ledring_pkg::*; #(
	parameter int RING_LEDS = RING_LEDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	frame_tick_if.sink tick,
	pixel_if.source    pixel,
	cfg_wr_if.sink     cfg
);

	cfg_regs_t   regs;
	logic        desc_valid;
	logic        desc_take;
	frame_desc_t desc;

	ledring_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ledring_frame_ctrl u_frame_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.regs       (regs),
		.desc_take  (desc_take),
		.desc_valid (desc_valid),
		.desc       (desc)
	);

	ledring_pixel_gen #(
		.RING_LEDS (RING_LEDS)
	) u_pixel_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_take  (desc_take),
		.regs       (regs),
		.pixel      (pixel)
	);

endmodule

### design/ledring_cfg_regs.sv
// Configuration register file of the LED ring pattern generator.
// Takes writes from the register channel. Depends on ledring_pkg and ledring_ifs.
module ledring_cfg_regs import ledring_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cfg_wr_if.sink    cfg,
	output cfg_regs_t regs
);

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.brightness       <= BRIGHTNESS_RST;
			regs_q.title_level      <= TITLE_LEVEL_RST;
			regs_q.play_hue_step    <= PLAY_STEP_RST;
			regs_q.victory_hue_step <= WIN_STEP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BRIGHTNESS:  regs_q.brightness       <= cfg.data;
				REG_TITLE_LEVEL: regs_q.title_level      <= cfg.data;
				REG_PLAY_STEP:   regs_q.play_hue_step    <= cfg.data;
				REG_WIN_STEP:    regs_q.victory_hue_step <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

### design/ledring_frame_ctrl.sv
// Frame decision logic: tracks shown mode, blink phase and hue, and turns each accepted tick,
// but a repeated title tick, into a pending frame description. Depends on ledring_pkg, ledring_ifs.
module ledring_frame_ctrl import ledring_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	frame_tick_if.sink  tick,
	input  cfg_regs_t   regs,
	input  logic        desc_take,
	output logic        desc_valid,
	output frame_desc_t desc
);

	logic [SHOWN_W-1:0] shown_q;
	logic               phase_q;
	logic [CH_W-1:0]    hue_q;
	logic               desc_valid_q;
	frame_desc_t        desc_q;

	logic               accept;
	logic               changed;
	logic               phase_eff;
	logic               emit;
	logic               phase_nxt;
	logic [CH_W-1:0]    hue_nxt;
	frame_desc_t        desc_nxt;

	assign tick.ready = !desc_valid_q || desc_take;
	assign accept     = tick.valid && tick.ready;
	assign desc_valid = desc_valid_q;
	assign desc       = desc_q;

	assign changed   = {1'b0, tick.game_mode} != shown_q;
	assign phase_eff = changed ? 1'b0 : phase_q;

	always_comb begin
		emit      = 1'b1;
		phase_nxt = phase_eff;
		hue_nxt   = hue_q;
		desc_nxt  = '{rainbow: 1'b0, hue: hue_q, color: '0};
		case (tick.game_mode)
			MODE_TITLE: begin
				emit           = changed;
				desc_nxt.color = '{red: regs.title_level, green: regs.title_level,
					blue: regs.title_level};
			end
			MODE_PLAY: begin
				desc_nxt.rainbow = 1'b1;
				hue_nxt          = hue_q + regs.play_hue_step;
			end
			MODE_OVER: begin
				phase_nxt = !phase_eff;
				if (!phase_eff) begin
					desc_nxt.color.red = regs.brightness;
				end
			end
			MODE_WIN: begin
				phase_nxt = !phase_eff;
				if (!phase_eff) begin
					desc_nxt.rainbow = 1'b1;
					hue_nxt          = hue_q + regs.victory_hue_step;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q      <= SHOWN_NONE;
			phase_q      <= 1'b0;
			hue_q        <= '0;
			desc_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				shown_q <= {1'b0, tick.game_mode};
				phase_q <= phase_nxt;
				hue_q   <= hue_nxt;
			end
			if (accept) begin
				desc_valid_q <= emit;
			end else if (desc_take) begin
				desc_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_q <= desc_nxt;
		end
	end

endmodule

### design/ledring_pixel_gen.sv
// Pixel sequencer and color pipeline: walks the ring one pixel per cycle unless
// the output stalls, evaluates the wheel and brightness product for rainbow frames,
// then scales it into the output register. Depends on ledring_pkg and ledring_ifs.
module ledring_pixel_gen import ledring_pkg::*; #(
	parameter int RING_LEDS = RING_LEDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        desc_valid,
	input  frame_desc_t desc,
	output logic        desc_take,
	input  cfg_regs_t   regs,
	pixel_if.source     pixel
);

	localparam int CNT_W = (RING_LEDS > 1) ? $clog2(RING_LEDS) : 1;
	localparam int REM_W = $clog2(RING_LEDS) + 1;
	localparam logic [CH_W-1:0]  STEP_WHOLE = CH_W'(256 / RING_LEDS);
	localparam logic [REM_W-1:0] STEP_REM   = REM_W'(256 % RING_LEDS);
	localparam logic [REM_W-1:0] RING_N     = REM_W'(RING_LEDS);
	localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(RING_LEDS - 1);

	logic              active_q;
	frame_desc_t       frame_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CH_W-1:0]   whole_q;
	logic [REM_W-1:0]  rem_q;

	logic              s1_v;
	logic              s1_scale;
	logic              s1_last;
	logic [CNT_W-1:0]  s1_idx;
	logic [PROD_W-1:0] s1_r;
	logic [PROD_W-1:0] s1_g;
	logic [PROD_W-1:0] s1_b;

	logic              out_v_q;
	logic              out_last_q;
	logic [CNT_W-1:0]  out_idx_q;
	rgb_t              out_rgb_q;

	logic              out_load;
	logic              s1_ready;
	logic              issue;
	logic              last_issue;
	logic [REM_W-1:0]  rem_sum;
	rgb_t              wheel;

	assign out_load   = !out_v_q || pixel.ready;
	assign s1_ready   = !s1_v || out_load;
	assign issue      = active_q && s1_ready;
	assign last_issue = issue && (cnt_q == CNT_LAST);
	assign desc_take  = desc_valid && (!active_q || last_issue);
	assign rem_sum    = rem_q + STEP_REM;
	assign wheel      = wheel_color(frame_q.hue + whole_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			s1_v     <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (desc_take) begin
				active_q <= 1'b1;
			end else if (last_issue) begin
				active_q <= 1'b0;
			end
			if (s1_ready) begin
				s1_v <= issue;
			end
			if (out_load) begin
				out_v_q <= s1_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_take) begin
			frame_q <= desc;
			cnt_q   <= '0;
			whole_q <= '0;
			rem_q   <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (rem_sum >= RING_N) begin
				rem_q   <= rem_sum - RING_N;
				whole_q <= whole_q + STEP_WHOLE + CH_W'(1);
			end else begin
				rem_q   <= rem_sum;
				whole_q <= whole_q + STEP_WHOLE;
			end
		end
		if (s1_ready) begin
			s1_idx   <= cnt_q;
			s1_last  <= cnt_q == CNT_LAST;
			s1_scale <= frame_q.rainbow;
			if (frame_q.rainbow) begin
				s1_r <= PROD_W'(wheel.red) * PROD_W'(regs.brightness);
				s1_g <= PROD_W'(wheel.green) * PROD_W'(regs.brightness);
				s1_b <= PROD_W'(wheel.blue) * PROD_W'(regs.brightness);
			end else begin
				s1_r <= PROD_W'(frame_q.color.red);
				s1_g <= PROD_W'(frame_q.color.green);
				s1_b <= PROD_W'(frame_q.color.blue);
			end
		end
		if (out_load) begin
			out_idx_q  <= s1_idx;
			out_last_q <= s1_last;
			if (s1_scale) begin
				out_rgb_q <= '{red: div255(s1_r), green: div255(s1_g), blue: div255(s1_b)};
			end else begin
				out_rgb_q <= '{red: s1_r[CH_W-1:0], green: s1_g[CH_W-1:0],
					blue: s1_b[CH_W-1:0]};
			end
		end
	end

	assign pixel.valid       = out_v_q;
	assign pixel.pixel_index = PIX_IDX_W'(out_idx_q);
	assign pixel.red         = out_rgb_q.red;
	assign pixel.green       = out_rgb_q.green;
	assign pixel.blue        = out_rgb_q.blue;
	assign pixel.last_pixel  = out_last_q;

endmodule

### test/testbench.sv
// Self-checking testbench for the LED ring pattern generator top level.
// Drives frame ticks and register writes, predicts every pixel of every frame
// and checks the pixel stream; depends on ledring_pkg and ledring_ifs.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ledring_pkg::*;

	localparam int LEDS         = RING_LEDS_DEF;
	localparam int QUIET_CYCLES = 2 * LEDS + 8;
	localparam int HOLD_CYCLES  = 120;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 36;

	typedef struct packed {
		logic [PIX_IDX_W-1:0] index;
		logic [CH_W-1:0]      red;
		logic [CH_W-1:0]      green;
		logic [CH_W-1:0]      blue;
		logic                 last;
	} ring_pixel_t;

	logic clk;
	logic arst_n;

	frame_tick_if tick_ch ();
	pixel_if      pix_ch ();
	cfg_wr_if     cfg_ch ();

	led_ring_pattern_generator_top #(
		.RING_LEDS(LEDS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_ch),
		.pixel (pix_ch),
		.cfg   (cfg_ch)
	);

	logic [CH_W-1:0]    lvl_brightness;
	logic [CH_W-1:0]    lvl_white;
	logic [CH_W-1:0]    step_play;
	logic [CH_W-1:0]    step_win;
	logic [SHOWN_W-1:0] mode_on_ring;
	logic               blink_off;
	logic [CH_W-1:0]    hue;

	ring_pixel_t pending_pixels[$];

	int  mismatch_cnt  = 0;
	int  ticks_sent    = 0;
	int  frames_made   = 0;
	int  pixels_seen   = 0;
	int  reg_writes    = 0;
	int  settings_used = 0;
	int  cycles        = 0;
	int  hold_requests = 0;
	int  holds_served  = 0;
	int  hold_left     = 0;
	bit  quiet_mode    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d pixels still awaited.", cycles,
			pending_pixels.size());
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [CH_W-1:0] scale_level(input int c);
		return CH_W'((c * int'(lvl_brightness)) / 255);
	endfunction

	function automatic void push_solid(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] b);
		for (int k = 0; k < LEDS; k++) begin
			pending_pixels.push_back('{index: PIX_IDX_W'(k), red: r, green: g, blue: b,
				last: (k == LEDS - 1)});
		end
		frames_made++;
	endfunction

	function automatic void push_rainbow();
		int p;
		int r;
		int g;
		int b;
		for (int k = 0; k < LEDS; k++) begin
			p = (int'(hue) + (k * 256) / LEDS) % 256;
			if (p < 85) begin
				r = 255 - 3 * p;
				g = 3 * p;
				b = 0;
			end else if (p < 170) begin
				p -= 85;
				r = 0;
				g = 255 - 3 * p;
				b = 3 * p;
			end else begin
				p -= 170;
				r = 3 * p;
				g = 0;
				b = 255 - 3 * p;
			end
			pending_pixels.push_back('{index: PIX_IDX_W'(k), red: scale_level(r),
				green: scale_level(g), blue: scale_level(b), last: (k == LEDS - 1)});
		end
		frames_made++;
	endfunction

	function automatic int predict_frame(input logic [MODE_W-1:0] mode);
		int  n;
		logic was_off;
		n = 0;
		if (SHOWN_W'(mode) != mode_on_ring) begin
			mode_on_ring = SHOWN_W'(mode);
			blink_off = 1'b0;
			if (mode == MODE_TITLE) begin
				push_solid(lvl_white, lvl_white, lvl_white);
				n = LEDS;
			end
		end
		case (mode)
			MODE_PLAY: begin
				push_rainbow();
				hue = hue + step_play;
				n = LEDS;
			end
			MODE_OVER: begin
				was_off = blink_off;
				blink_off = ~blink_off;
				if (was_off) begin
					push_solid('0, '0, '0);
				end else begin
					push_solid(lvl_brightness, '0, '0);
				end
				n = LEDS;
			end
			MODE_WIN: begin
				was_off = blink_off;
				blink_off = ~blink_off;
				if (was_off) begin
					push_solid('0, '0, '0);
				end else begin
					push_rainbow();
					hue = hue + step_win;
				end
				n = LEDS;
			end
			default: begin
			end
		endcase
		return n;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CH_W-1:0] val);
		case (idx)
			REG_BRIGHTNESS:  lvl_brightness = val;
			REG_TITLE_LEVEL: lvl_white = val;
			REG_PLAY_STEP:   step_play = val;
			REG_WIN_STEP:    step_win = val;
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("%s", msg);
		end
	endtask

	initial begin
		ring_pixel_t want;
		ring_pixel_t got;
		forever begin
			@(posedge clk);
			if (arst_n && pix_ch.valid && pix_ch.ready) begin
				got = '{index: pix_ch.pixel_index, red: pix_ch.red, green: pix_ch.green,
					blue: pix_ch.blue, last: pix_ch.last_pixel};
				pixels_seen++;
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("Unexpected pixel idx %0d rgb %0d/%0d/%0d last %0b",
						got.index, got.red, got.green, got.blue, got.last));
				end else begin
					want = pending_pixels.pop_front();
					if (got.index !== want.index || got.red !== want.red
						|| got.green !== want.green || got.blue !== want.blue
						|| got.last !== want.last) begin
						report_mismatch($sformatf({"Pixel mismatch: expected idx %0d rgb %0d/%0d/%0d",
							" last %0b, got idx %0d rgb %0d/%0d/%0d last %0b"},
							want.index, want.red, want.green, want.blue, want.last,
							got.index, got.red, got.green, got.blue, got.last));
					end
				end
			end
		end
	end

	initial begin
		pix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_ch.ready <= 1'b0;
			end else if (quiet_mode) begin
				pix_ch.ready <= 1'b1;
			end else begin
				pix_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_tick(input logic [MODE_W-1:0] mode, output int n);
		while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.game_mode <= mode;
		do begin
			@(posedge clk);
		end while (!tick_ch.ready);
		ticks_sent++;
		n = predict_frame(mode);
	endtask

	task automatic send_modes(input logic [MODE_W-1:0] modes[$]);
		int n;
		foreach (modes[k]) begin
			send_tick(modes[k], n);
		end
	endtask

	task automatic wait_frames_done();
		tick_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic settle_block();
		wait_frames_done();
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CH_W-1:0] b, input logic [CH_W-1:0] w,
		input logic [CH_W-1:0] ps, input logic [CH_W-1:0] vs);
		logic [CFG_IDX_W-1:0] idx[5];
		logic [CH_W-1:0]      val[5];
		idx = '{CFG_IDX_W'(int'(REG_WIN_STEP) + 1 + $urandom_range(11)), REG_BRIGHTNESS,
			REG_TITLE_LEVEL, REG_PLAY_STEP, REG_WIN_STEP};
		val = '{CH_W'($urandom), b, w, ps, vs};
		settle_block();
		for (int k = 0; k < 5; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[k];
			cfg_ch.data <= val[k];
			do begin
				@(posedge clk);
			end while (!cfg_ch.ready);
			apply_reg(idx[k], val[k]);
			reg_writes++;
		end
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [CH_W-1:0] pick_level();
		int sel;
		sel = $urandom_range(3);
		if (sel == 0) begin
			return '0;
		end else if (sel == 1) begin
			return CH_MAX;
		end
		return CH_W'($urandom);
	endfunction

	task automatic test_reset_defaults();
		send_modes('{MODE_TITLE, MODE_TITLE, MODE_PLAY, MODE_PLAY, MODE_PLAY, MODE_OVER,
			MODE_OVER, MODE_OVER, MODE_WIN, MODE_WIN, MODE_WIN, MODE_TITLE, MODE_WIN,
			MODE_OVER});
	endtask

	task automatic test_register_extremes();
		program_regs(CH_MAX, CH_MAX, CH_MAX, CH_MAX);
		send_modes('{MODE_PLAY, MODE_PLAY, MODE_WIN, MODE_WIN, MODE_TITLE});
		program_regs('0, '0, '0, '0);
		send_modes('{MODE_TITLE, MODE_OVER, MODE_PLAY, MODE_PLAY, MODE_WIN, MODE_TITLE});
	endtask

	task automatic test_output_backpressure();
		int n;
		program_regs(BRIGHTNESS_RST, TITLE_LEVEL_RST, PLAY_STEP_RST, WIN_STEP_RST);
		hold_requests++;
		for (int k = 0; k < 6; k++) begin
			send_tick(MODE_PLAY, n);
		end
		wait_frames_done();
		send_modes('{MODE_OVER, MODE_OVER, MODE_WIN});
		wait_frames_done();
	endtask

	task automatic test_random_frames();
		int              made;
		int              run;
		int              n;
		logic [MODE_W-1:0] mode;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0) begin
				program_regs(CH_MAX, '0, CH_MAX, 8'd1);
			end else begin
				program_regs(pick_level(), pick_level(), pick_level(), pick_level());
			end
			quiet_mode = (phase == 2);
			made = 0;
			while (made < 29) begin
				mode = MODE_W'($urandom_range(3));
				run = $urandom_range(1, 10);
				for (int k = 0; k < run && made < 29; k++) begin
					send_tick(mode, n);
					made++;
				end
			end
			wait_frames_done();
			quiet_mode = 1'b0;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		tick_ch.valid <= 1'b0;
		tick_ch.game_mode <= MODE_TITLE;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_BRIGHTNESS;
		cfg_ch.data <= '0;
		lvl_brightness = BRIGHTNESS_RST;
		lvl_white = TITLE_LEVEL_RST;
		step_play = PLAY_STEP_RST;
		step_win = WIN_STEP_RST;
		mode_on_ring = SHOWN_NONE;
		blink_off = 1'b0;
		hue = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_output_backpressure();
		test_random_frames();
		settle_block();

		if (pending_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d expected pixels never arrived.",
				pending_pixels.size()));
		end
		$display("Ran %0d frame ticks giving %0d frames; checked %0d pixels.", ticks_sent,
			frames_made, pixels_seen);
		$display("Made %0d register writes across %0d register settings; %0d mismatches.",
			reg_writes, settings_used, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
